// File: hdl/key_press_long_press_detector_defines.svh
// ----------------------------------------------------------------------------
// Key long-press detector: assertion macros
// Shared property wrappers clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef KEY_PRESS_LONG_PRESS_DETECTOR_DEFINES_SVH
`define KEY_PRESS_LONG_PRESS_DETECTOR_DEFINES_SVH

// same-cycle implication
`define KLPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KLPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/klpd_pkg.sv
// ----------------------------------------------------------------------------
// Key long-press detector package
// Widths, key modes and the word types passed between front, queue and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package klpd_pkg;

  localparam int LEVEL_BITS      = 4;
  localparam int KEY_IDX_W       = 2;
  localparam int TIME_W          = 32;
  localparam int THR_W           = 16;
  localparam int KEY_COUNT_DEF   = 4;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [THR_W-1:0] THR_RESET = 16'd2000;

  localparam logic KIND_PRESS = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  typedef enum logic [1:0] {
    MODE_RELEASED = 2'd0,
    MODE_PRESSED  = 2'd1,
    MODE_LONG     = 2'd2
  } key_mode_e;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] ev_mask;
    logic [LEVEL_BITS-1:0] ev_kind;
    logic [TIME_W-1:0]     stamp;
  } scan_t;

  typedef struct packed {
    logic                  cur_valid;
    logic [LEVEL_BITS-1:0] cur_mask;
  } back_stat_t;

endpackage

// File: hdl/klpd_front.sv
// ----------------------------------------------------------------------------
// Key long-press detector: front end
// Runs the per-key mode machines on each accepted scan and forms one word
// holding the event mask, kinds and scan time for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module klpd_front #(
  parameter int KEY_COUNT = klpd_pkg::KEY_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [klpd_pkg::THR_W-1:0]       cfg_wdata_i,
  input  logic                             push_i,
  input  logic [klpd_pkg::LEVEL_BITS-1:0]  key_levels_i,
  input  logic [klpd_pkg::TIME_W-1:0]      now_ticks_i,
  input  logic                             q_full_i,
  output logic                             full_o,
  output logic                             q_push_o,
  output klpd_pkg::scan_t                  q_data_o
);

  logic [klpd_pkg::THR_W-1:0]  thr_q;
  klpd_pkg::key_mode_e         mode_q  [KEY_COUNT];
  klpd_pkg::key_mode_e         mode_d  [KEY_COUNT];
  logic [klpd_pkg::TIME_W-1:0] start_q [KEY_COUNT];
  logic [KEY_COUNT-1:0]        start_we;
  logic                        accept;
  klpd_pkg::scan_t             scan;

  assign accept = push_i && !q_full_i;
  assign full_o = q_full_i;

  always_comb begin
    logic                        down;
    logic [klpd_pkg::TIME_W-1:0] held;
    scan       = '0;
    scan.stamp = now_ticks_i;
    start_we   = '0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      down      = (i < klpd_pkg::LEVEL_BITS) &&
                  key_levels_i[i[klpd_pkg::KEY_IDX_W-1:0]];
      held      = now_ticks_i - start_q[i];
      mode_d[i] = mode_q[i];
      unique case (mode_q[i])
        klpd_pkg::MODE_PRESSED: begin
          if (!down) begin
            mode_d[i] = klpd_pkg::MODE_RELEASED;
          end else if (held > {{(klpd_pkg::TIME_W-klpd_pkg::THR_W){1'b0}}, thr_q}) begin
            mode_d[i] = klpd_pkg::MODE_LONG;
            if (i < klpd_pkg::LEVEL_BITS) begin
              scan.ev_mask[i[klpd_pkg::KEY_IDX_W-1:0]] = 1'b1;
              scan.ev_kind[i[klpd_pkg::KEY_IDX_W-1:0]] = klpd_pkg::KIND_LONG;
            end
          end
        end
        klpd_pkg::MODE_LONG: begin
          if (!down) begin
            mode_d[i] = klpd_pkg::MODE_RELEASED;
          end
        end
        default: begin
          mode_d[i] = klpd_pkg::MODE_RELEASED;
          if (down) begin
            mode_d[i]   = klpd_pkg::MODE_PRESSED;
            start_we[i] = 1'b1;
            if (i < klpd_pkg::LEVEL_BITS) begin
              scan.ev_mask[i[klpd_pkg::KEY_IDX_W-1:0]] = 1'b1;
              scan.ev_kind[i[klpd_pkg::KEY_IDX_W-1:0]] = klpd_pkg::KIND_PRESS;
            end
          end
        end
      endcase
    end
  end

  assign q_push_o = accept && (scan.ev_mask != '0);
  assign q_data_o = scan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= klpd_pkg::THR_RESET;
      for (int i = 0; i < KEY_COUNT; i++) begin
        mode_q[i] <= klpd_pkg::MODE_RELEASED;
      end
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (accept) begin
        for (int i = 0; i < KEY_COUNT; i++) begin
          mode_q[i] <= mode_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (accept && start_we[i]) begin
        start_q[i] <= now_ticks_i;
      end
    end
  end

endmodule

// File: hdl/klpd_queue.sv
// ----------------------------------------------------------------------------
// Key long-press detector: scan queue
// Short first-in first-out buffer of scan words between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module klpd_queue #(
  parameter int DEPTH = klpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  klpd_pkg::scan_t data_i,
  input  logic            pop_i,
  output klpd_pkg::scan_t data_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  klpd_pkg::scan_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hdl/klpd_back.sv
// ----------------------------------------------------------------------------
// Key long-press detector: back end
// Takes scan words from the queue and, while the receiver pops, issues their
// events one per cycle in ascending key order through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module klpd_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  klpd_pkg::scan_t                   q_data_i,
  input  logic                              q_empty_i,
  output logic                              q_pop_o,
  input  logic                              pop_i,
  output logic                              empty_o,
  output logic [klpd_pkg::KEY_IDX_W-1:0]    key_index_o,
  output logic                              event_kind_o,
  output logic [klpd_pkg::TIME_W-1:0]       event_time_o,
  output logic                              last_event_o,
  output klpd_pkg::back_stat_t              stat_o
);

  klpd_pkg::scan_t                 cur_q, cur_d;
  logic                            cur_valid_q, cur_valid_d;
  logic                            out_valid_q, out_valid_d;
  logic [klpd_pkg::KEY_IDX_W-1:0]  key_index_q;
  logic                            event_kind_q;
  logic [klpd_pkg::TIME_W-1:0]     event_time_q;
  logic                            last_event_q;
  logic                            out_ready;
  logic                            issue;
  logic [klpd_pkg::KEY_IDX_W-1:0]  idx;
  logic [klpd_pkg::LEVEL_BITS-1:0] rem_mask;

  always_comb begin
    idx = '0;
    for (int k = klpd_pkg::LEVEL_BITS - 1; k >= 0; k--) begin
      if (cur_q.ev_mask[k]) begin
        idx = k[klpd_pkg::KEY_IDX_W-1:0];
      end
    end
  end

  assign rem_mask  = cur_q.ev_mask & ~(klpd_pkg::LEVEL_BITS'(1) << idx);
  assign out_ready = !out_valid_q || pop_i;
  assign issue     = cur_valid_q && out_ready;
  assign q_pop_o   = !q_empty_i && (!cur_valid_q || (issue && (rem_mask == '0)));

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    out_valid_d = out_valid_q;
    if (issue) begin
      cur_d.ev_mask = rem_mask;
      cur_valid_d   = (rem_mask != '0);
      out_valid_d   = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
    if (q_pop_o) begin
      cur_d       = q_data_i;
      cur_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (issue) begin
      key_index_q  <= idx;
      event_kind_q <= cur_q.ev_kind[idx];
      event_time_q <= cur_q.stamp;
      last_event_q <= (rem_mask == '0);
    end
  end

  assign key_index_o      = key_index_q;
  assign event_kind_o     = event_kind_q;
  assign event_time_o     = event_time_q;
  assign last_event_o     = last_event_q;
  assign empty_o          = !out_valid_q;
  assign stat_o.cur_valid = cur_valid_q;
  assign stat_o.cur_mask  = cur_q.ev_mask;

endmodule

// File: hdl/key_press_long_press_detector.sv
// Key long-press detector. One scan word (key levels plus tick time) is taken
// per clock while the internal scan queue has room; each scan produces zero to
// four events (press or long press), issued one per clock while the receiver
// pops, in ascending key order from a single output register, the last of a
// scan flagged by last_event_o. New scans enter the queue while older events
// are still issued; a scan passes the queue, the pending-scan register and
// the output register in turn. Scans with no event produce no output.
// ----------------------------------------------------------------------------
// Key long-press detector: top level
// Front end mode machines, scan queue and event issue back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "key_press_long_press_detector_defines.svh"

module key_press_long_press_detector #(
  parameter int KEY_COUNT   = klpd_pkg::KEY_COUNT_DEF,
  parameter int QUEUE_DEPTH = klpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [klpd_pkg::THR_W-1:0]       cfg_wdata_i,
  input  logic                             push,
  output logic                             full,
  input  logic [klpd_pkg::LEVEL_BITS-1:0]  key_levels_i,
  input  logic [klpd_pkg::TIME_W-1:0]      now_ticks_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [klpd_pkg::KEY_IDX_W-1:0]   key_index_o,
  output logic                             event_kind_o,
  output logic [klpd_pkg::TIME_W-1:0]      event_time_o,
  output logic                             last_event_o
);

  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;
  klpd_pkg::scan_t      q_wdata;
  klpd_pkg::scan_t      q_rdata;
  klpd_pkg::back_stat_t back_stat;

  klpd_front #(
    .KEY_COUNT (KEY_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push_i       (push),
    .key_levels_i (key_levels_i),
    .now_ticks_i  (now_ticks_i),
    .q_full_i     (q_full),
    .full_o       (full),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata)
  );

  klpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  klpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_data_i     (q_rdata),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .key_index_o  (key_index_o),
    .event_kind_o (event_kind_o),
    .event_time_o (event_time_o),
    .last_event_o (last_event_o),
    .stat_o       (back_stat)
  );

  `KLPD_ASSERT_IMP(a_cur_mask_live, back_stat.cur_valid, back_stat.cur_mask != '0,
                   "pending scan holds no event")
  `KLPD_ASSERT_NXT(a_cur_feeds_out, back_stat.cur_valid, !empty,
                   "pending event not presented")
  `KLPD_ASSERT_NXT(a_scan_continues, pop && !empty && !last_event_o,
                   !empty && (event_time_o == $past(event_time_o)) &&
                   (key_index_o > $past(key_index_o)),
                   "scan events broken or out of key order")

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key long-press detector testbench
// Sends scan words through the input queue port and keeps a model of the four
// key machines, from which it predicts the press and long-press events. Every
// event popped from the block is compared field by field with the oldest
// prediction. The run covers directed cases at the threshold, zero and wrap
// limits, a long receiver hold-off that fills the block, and random phases
// under several thresholds.
// ----------------------------------------------------------------------------

module tb_top;
  import klpd_pkg::*;

  localparam int KEYS       = KEY_COUNT_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_WAIT = 20;
  localparam int HOLD_LEN   = 400;

  typedef struct packed {
    logic [KEY_IDX_W-1:0] key;
    logic                 kind;
    logic [TIME_W-1:0]    stamp;
    logic                 last;
  } key_event_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [THR_W-1:0]      cfg_wdata_i  = '0;
  logic                  push         = 1'b0;
  logic                  full;
  logic [LEVEL_BITS-1:0] key_levels_i = '0;
  logic [TIME_W-1:0]     now_ticks_i  = '0;
  logic                  empty;
  logic                  pop          = 1'b0;
  logic [KEY_IDX_W-1:0]  key_index_o;
  logic                  event_kind_o;
  logic [TIME_W-1:0]     event_time_o;
  logic                  last_event_o;

  key_mode_e         mode_q  [KEYS];
  logic [TIME_W-1:0] start_q [KEYS];
  logic [THR_W-1:0]  thr_q;
  key_event_t        pending_events [$];
  key_event_t        head_ev;

  logic [TIME_W-1:0]     scan_time;
  logic [LEVEL_BITS-1:0] scan_levels;
  int                    errors    = 0;
  int                    idle_cnt  = 0;
  int                    stall_cnt = 0;
  int                    hold_req  = 0;
  int                    hold_seen = 0;
  bit                    quiet     = 1'b0;

  key_press_long_press_detector u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .key_levels_i (key_levels_i),
    .now_ticks_i  (now_ticks_i),
    .empty        (empty),
    .pop          (pop),
    .key_index_o  (key_index_o),
    .event_kind_o (event_kind_o),
    .event_time_o (event_time_o),
    .last_event_o (last_event_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic advance_keys(input logic [LEVEL_BITS-1:0] lv, input logic [TIME_W-1:0] now);
    key_event_t        batch [$];
    key_event_t        ev;
    logic [TIME_W-1:0] held;
    int                k;
    for (k = 0; k < KEYS; k++) begin
      ev.key   = k[KEY_IDX_W-1:0];
      ev.stamp = now;
      ev.last  = 1'b0;
      case (mode_q[k])
        MODE_PRESSED: begin
          held = now - start_q[k];
          if (!lv[k]) begin
            mode_q[k] = MODE_RELEASED;
          end else if (held > {{(TIME_W-THR_W){1'b0}}, thr_q}) begin
            mode_q[k] = MODE_LONG;
            ev.kind   = KIND_LONG;
            batch.push_back(ev);
          end
        end
        MODE_LONG: begin
          if (!lv[k]) mode_q[k] = MODE_RELEASED;
        end
        default: begin
          mode_q[k] = MODE_RELEASED;
          if (lv[k]) begin
            mode_q[k]  = MODE_PRESSED;
            start_q[k] = now;
            ev.kind    = KIND_PRESS;
            batch.push_back(ev);
          end
        end
      endcase
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) pending_events.push_back(batch[i]);
  endtask

  task automatic send_scan(input logic [LEVEL_BITS-1:0] lv, input logic [TIME_W-1:0] now);
    if (!quiet && $urandom_range(3, 0) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(11, 1)) @(posedge clk_i);
    end
    push         <= 1'b1;
    key_levels_i <= lv;
    now_ticks_i  <= now;
    do @(posedge clk_i); while (full);
    advance_keys(lv, now);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic set_long_press_ticks(input logic [THR_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    thr_q = value;
  endtask

  task automatic test_default_threshold();
    send_scan(4'h0, 32'd0);
    send_scan(4'h1, 32'd100);
    send_scan(4'h1, 32'd2100);
    send_scan(4'h1, 32'd2101);
    send_scan(4'h1, 32'd9000);
    send_scan(4'h0, 32'd9001);
    send_scan(4'hF, 32'd10000);
    send_scan(4'hA, 32'd12001);
    send_scan(4'h0, 32'd12002);
  endtask

  task automatic test_zero_threshold();
    set_long_press_ticks('0);
    send_scan(4'h4, 32'd500);
    send_scan(4'h4, 32'd500);
    send_scan(4'h4, 32'd501);
    send_scan(4'h0, 32'd502);
  endtask

  task automatic test_time_wrap();
    set_long_press_ticks('1);
    send_scan(4'h8, 32'hFFFF_FF00);
    send_scan(4'h8, 32'h0000_FEFF);
    send_scan(4'h8, 32'h0000_FF00);
    send_scan(4'h0, 32'hFFFF_FFFF);
  endtask

  task automatic test_backpressure();
    int i;
    set_long_press_ticks(16'd5);
    quiet = 1'b1;
    hold_req++;
    scan_time = $urandom;
    for (i = 0; i < 40; i++) begin
      scan_time += $urandom_range(8, 0);
      send_scan(4'($urandom), scan_time);
    end
    quiet = 1'b0;
  endtask

  task automatic run_random_scans(input int count);
    int i;
    int k;
    scan_time   = $urandom;
    scan_levels = '0;
    for (i = 0; i < count; i++) begin
      case ($urandom_range(15, 0))
        0:       scan_time = $urandom;
        1:       ;
        default: scan_time += $urandom_range(int'(thr_q) / 4 + 2, 0);
      endcase
      if ($urandom_range(15, 0) == 0) begin
        scan_levels = 4'($urandom);
      end else begin
        for (k = 0; k < LEVEL_BITS; k++)
          if ($urandom_range(7, 0) == 0) scan_levels[k] = ~scan_levels[k];
      end
      send_scan(scan_levels, scan_time);
    end
  endtask

  task automatic test_random();
    set_long_press_ticks('0);
    run_random_scans(70);
    set_long_press_ticks('1);
    run_random_scans(70);
    set_long_press_ticks(16'($urandom_range(50, 1)));
    run_random_scans(70);
    set_long_press_ticks(16'($urandom));
    run_random_scans(70);
  endtask

  task automatic test_quiet_tail();
    set_long_press_ticks(16'($urandom_range(20, 1)));
    quiet = 1'b1;
    run_random_scans(20);
  endtask

  initial begin
    thr_q = THR_RESET;
    foreach (mode_q[k]) begin
      mode_q[k]  = MODE_RELEASED;
      start_q[k] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_threshold();
    test_zero_threshold();
    test_time_wrap();
    test_backpressure();
    test_random();
    test_quiet_tail();
    wait_idle();
    if (errors == 0 && pending_events.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      stall_cnt = HOLD_LEN;
    end
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (stall_cnt > 0) begin
      pop <= 1'b0;
      stall_cnt--;
    end else if (!quiet && $urandom_range(5, 0) == 0) begin
      pop <= 1'b0;
      stall_cnt = $urandom_range(11, 1) - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input logic [TIME_W-1:0] exp_v,
                                      input logic [TIME_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_events.size() == 0) begin
        $error("event with none expected: key %0d kind %0d time 0x%0h",
               key_index_o, event_kind_o, event_time_o);
        errors++;
      end else begin
        head_ev = pending_events.pop_front();
        check_field("key_index", TIME_W'(head_ev.key), TIME_W'(key_index_o));
        check_field("event_kind", TIME_W'(head_ev.kind), TIME_W'(event_kind_o));
        check_field("event_time", head_ev.stamp, event_time_o);
        check_field("last_event", TIME_W'(head_ev.last), TIME_W'(last_event_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/klpd_pkg.sv
hdl/klpd_front.sv
hdl/klpd_queue.sv
hdl/klpd_back.sv
hdl/key_press_long_press_detector.sv
verif/tb_top.sv
